@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SCI_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define SCI_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sci_pkg.sv @@
package sci_pkg;

  localparam int SW      = 66;
  localparam int TW      = 17;
  localparam int CfgW    = 32;
  localparam int AddrW   = 3;

  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = 3;

  localparam int FrontStages = 8;
  localparam int BackStages  = SW + TW + 5;

  localparam logic [CfgW-1:0] ThreshReset = 32'd42950;
  localparam logic            RegThresh   = 1'b0;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ONE,
    CLS_TWO
  } root_cls_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [30:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } seg_t;

  typedef struct packed {
    root_cls_t          cls;
    logic signed [66:0] h;
    logic        [65:0] a;
    seg_t               seg;
  } job_t;

  typedef struct packed {
    logic [131:0] q;
    job_t         job;
  } work_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [16:0] t;
  } point_t;

endpackage

@@ sv/sci_in_if.sv @@
interface sci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic        [30:0] radius;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y, radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y, radius,
    output ready
  );
endinterface

@@ sv/sci_out_if.sv @@
interface sci_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        [16:0] param_t;
  logic               last;

  modport source (
    output valid, hit, point_x, point_y, point_z, param_t, last,
    input  ready
  );
  modport sink (
    input  valid, hit, point_x, point_y, point_z, param_t, last,
    output ready
  );
endinterface

@@ sv/segment_circle_intersect_xy_unit.sv @@
// Segment versus circle intersection in the XY plane.
// in_if carries one query word: segment start and end (Q24.8, Z included),
// circle center and radius. out_if returns one to two words per query: a
// word with hit=1 per crossing point in segment order (param_t in Q1.16),
// or a single word with hit=0 and zero fields when nothing is hit. last
// marks the final word of a query. tangent_threshold sits at APB offset 0.
// 8 front stages form the quadratic and classify it, then the back pipeline
// runs a 66 stage square root (one root bit per stage), a 17 stage divider
// (two lanes, one quotient bit per stage) and the interpolation. The back
// takes one query per cycle while the output is not stalled; a query with
// two points holds the output register, and the back with it, until both
// words are taken. A 4 word queue sits between front and back.
// Reset clears all valid flags and loads the threshold with its default.
// When the receiver stalls, the output register holds its word, the back
// pipeline halts when its last stage is full, the front when the queue fills.
module segment_circle_intersect_xy_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  sci_in_if.sink                     in_if,
  sci_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sci_pkg::AddrW-1:0]  paddr,
  input  logic [sci_pkg::CfgW-1:0]   pwdata,
  output logic [sci_pkg::CfgW-1:0]   prdata,
  output logic                       pready
);

  sci_pkg::in_item_t in_item;
  sci_pkg::work_t    q_wdata, q_rdata;
  sci_pkg::point_t   out_word;
  logic [31:0]       thresh;
  logic              q_push, q_pop, q_full, q_empty;

  always_comb begin
    in_item.start_x  = in_if.start_x;
    in_item.start_y  = in_if.start_y;
    in_item.start_z  = in_if.start_z;
    in_item.end_x    = in_if.end_x;
    in_item.end_y    = in_if.end_y;
    in_item.end_z    = in_if.end_z;
    in_item.center_x = in_if.center_x;
    in_item.center_y = in_if.center_y;
    in_item.radius   = in_if.radius;
  end

  assign out_if.hit     = out_word.hit;
  assign out_if.point_x = out_word.px;
  assign out_if.point_y = out_word.py;
  assign out_if.point_z = out_word.pz;
  assign out_if.param_t = out_word.t;

  sci_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thresh  (thresh)
  );

  sci_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_item  (in_item),
    .thresh   (thresh),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sci_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_word),
    .out_last  (out_if.last)
  );

endmodule

@@ sv/sci_cfg.sv @@
module sci_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] thresh
);

  logic [31:0] thresh_r;
  logic        sel_thresh;

  assign sel_thresh = (paddr[2] == sci_pkg::RegThresh);
  assign pready     = 1'b1;
  assign prdata     = sel_thresh ? thresh_r : 32'd0;
  assign thresh     = thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= sci_pkg::ThreshReset;
    end else if (psel && penable && pwrite && sel_thresh) begin
      thresh_r <= pwdata;
    end
  end

endmodule

@@ sv/sci_front.sv @@
module sci_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sci_pkg::in_item_t in_item,
  input  logic [31:0]       thresh,
  input  logic              q_full,
  output logic              q_push,
  output sci_pkg::work_t    q_wdata
);

  logic [sci_pkg::FrontStages-1:0] v_r;
  logic                            en;

  sci_pkg::seg_t      seg_r [1:7];
  logic signed [32:0] fx_r, fy_r;
  logic        [30:0] rad_r;

  logic signed [65:0] dxdx_r, dydy_r, dxfx_r, dyfy_r, fxfx_r, fyfy_r;
  logic        [61:0] rr_r;

  logic        [65:0] a_r  [3:7];
  logic signed [66:0] h_r  [3:7];
  logic signed [66:0] c_r;

  logic [65:0] habs_r, cabs_r;
  logic        cneg_r [4:6];

  logic [65:0] hh_r, hl_r, ll_r, ac_hh_r, ac_hl_r, ac_lh_r, ac_ll_r;
  logic [131:0] hsq_r, ac_r;
  logic [132:0] q_r;

  sci_pkg::work_t work_r;

  logic [65:0]  habs_nxt, cabs_nxt;
  logic [131:0] hsq_nxt, ac_nxt, qv;
  logic         tiny_q;
  sci_pkg::work_t work_nxt;

  assign en       = !v_r[sci_pkg::FrontStages-1] || !q_full;
  assign in_ready = en;
  assign q_push   = v_r[sci_pkg::FrontStages-1] && !q_full;
  assign q_wdata  = work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[sci_pkg::FrontStages-2:0], in_valid};
    end
  end

  always_comb begin
    habs_nxt = h_r[3][66] ? 66'(~h_r[3] + 67'd1) : h_r[3][65:0];
    cabs_nxt = c_r[66]    ? 66'(~c_r + 67'd1)    : c_r[65:0];
    hsq_nxt  = {hh_r, 66'd0} + {32'd0, hl_r, 34'd0} + {66'd0, ll_r};
    ac_nxt   = {ac_hh_r, 66'd0} + {33'd0, ac_hl_r, 33'd0} + {33'd0, ac_lh_r, 33'd0}
             + {66'd0, ac_ll_r};
    qv       = q_r[131:0];
    tiny_q   = (qv[131:30] == '0) && ({qv[29:0], 2'b00} < thresh);
    work_nxt.job.seg = seg_r[7];
    work_nxt.job.a   = a_r[7];
    work_nxt.job.h   = h_r[7];
    work_nxt.q       = '0;
    if ((a_r[7] == '0) || q_r[132]) begin
      work_nxt.job.cls = sci_pkg::CLS_NONE;
    end else if ((qv == '0) || tiny_q) begin
      work_nxt.job.cls = sci_pkg::CLS_ONE;
    end else begin
      work_nxt.job.cls = sci_pkg::CLS_TWO;
      work_nxt.q       = qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // differences
      seg_r[1].sx <= in_item.start_x;
      seg_r[1].sy <= in_item.start_y;
      seg_r[1].sz <= in_item.start_z;
      seg_r[1].dx <= {in_item.end_x[31], in_item.end_x} - {in_item.start_x[31], in_item.start_x};
      seg_r[1].dy <= {in_item.end_y[31], in_item.end_y} - {in_item.start_y[31], in_item.start_y};
      seg_r[1].dz <= {in_item.end_z[31], in_item.end_z} - {in_item.start_z[31], in_item.start_z};
      fx_r  <= {in_item.start_x[31], in_item.start_x} - {in_item.center_x[31], in_item.center_x};
      fy_r  <= {in_item.start_y[31], in_item.start_y} - {in_item.center_y[31], in_item.center_y};
      rad_r <= in_item.radius;
      for (int i = 2; i <= 7; i++) begin
        seg_r[i] <= seg_r[i-1];
      end
      // squares and cross products
      dxdx_r <= seg_r[1].dx * seg_r[1].dx;
      dydy_r <= seg_r[1].dy * seg_r[1].dy;
      dxfx_r <= seg_r[1].dx * fx_r;
      dyfy_r <= seg_r[1].dy * fy_r;
      fxfx_r <= fx_r * fx_r;
      fyfy_r <= fy_r * fy_r;
      rr_r   <= rad_r * rad_r;
      // quadratic terms
      a_r[3] <= dxdx_r[65:0] + dydy_r[65:0];
      h_r[3] <= {dxfx_r[65], dxfx_r} + {dyfy_r[65], dyfy_r};
      c_r    <= {1'b0, fxfx_r} + {1'b0, fyfy_r} - {5'd0, rr_r};
      for (int i = 4; i <= 7; i++) begin
        a_r[i] <= a_r[i-1];
        h_r[i] <= h_r[i-1];
      end
      habs_r    <= habs_nxt;
      cabs_r    <= cabs_nxt;
      cneg_r[4] <= c_r[66];
      cneg_r[5] <= cneg_r[4];
      cneg_r[6] <= cneg_r[5];
      // partial products of h*h and a*|c|
      hh_r    <= habs_r[65:33] * habs_r[65:33];
      hl_r    <= habs_r[65:33] * habs_r[32:0];
      ll_r    <= habs_r[32:0]  * habs_r[32:0];
      ac_hh_r <= a_r[4][65:33] * cabs_r[65:33];
      ac_hl_r <= a_r[4][65:33] * cabs_r[32:0];
      ac_lh_r <= a_r[4][32:0]  * cabs_r[65:33];
      ac_ll_r <= a_r[4][32:0]  * cabs_r[32:0];
      hsq_r   <= hsq_nxt;
      ac_r    <= ac_nxt;
      // quarter discriminant
      q_r     <= cneg_r[6] ? ({1'b0, hsq_r} + {1'b0, ac_r}) : ({1'b0, hsq_r} - {1'b0, ac_r});
      work_r  <= work_nxt;
    end
  end

endmodule

@@ sv/sci_queue.sv @@
`include "assert_macros.svh"

module sci_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sci_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output sci_pkg::work_t rdata,
  output logic           empty
);

  sci_pkg::work_t mem_r [sci_pkg::QDepth];
  logic [sci_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [sci_pkg::QCntW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'(sci_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 3'd1;
      2'b01:   cnt_nxt = cnt_r - 3'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  `SCI_CHECK(a_q_bound, cnt_r <= 3'(sci_pkg::QDepth), "queue count above depth")
  `SCI_CHECK(a_q_no_overrun, !(push && full), "word pushed into full queue")
  `SCI_CHECK_NEXT(a_q_grow, push && !pop, cnt_r == $past(cnt_r) + 3'd1, "queue count did not grow")

endmodule

@@ sv/sci_back.sv @@
`include "assert_macros.svh"

module sci_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sci_pkg::work_t  q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output sci_pkg::point_t out_word,
  output logic            out_last
);

  localparam int Last = sci_pkg::BackStages - 1;

  logic [sci_pkg::BackStages-1:0] v_r;
  logic en, load, fire, cur_last, free;

  // square root pipeline, one root bit per stage
  logic [131:0]  rem_r    [0:sci_pkg::SW];
  logic [65:0]   root_r   [0:sci_pkg::SW];
  sci_pkg::job_t sq_job_r [0:sci_pkg::SW];

  logic signed [67:0] nm0_r, nm1_r;
  sci_pkg::job_t      n1_job_r;

  // division pipeline, two lanes, one quotient bit per stage
  logic [81:0]   dv_n_r   [0:sci_pkg::TW][2];
  logic [16:0]   dv_t_r   [0:sci_pkg::TW][2];
  logic [1:0]    dv_ok_r  [0:sci_pkg::TW];
  sci_pkg::job_t dv_job_r [0:sci_pkg::TW];

  logic signed [50:0] pr_r [2][3];
  logic [16:0]        l1_t_r [2];
  logic [1:0]         l1_ok_r;
  sci_pkg::seg_t      l1_seg_r;

  sci_pkg::point_t w0_r, w1_r, w0_nxt, w1_nxt;
  logic            two_r, two_nxt;
  sci_pkg::point_t pt [2];

  logic               hold_v_r, idx_r, e_two_r;
  sci_pkg::point_t    e_w0_r, e_w1_r;

  logic signed [67:0] nh, sq_ext;
  logic signed [67:0] nm0_nxt, nm1_nxt;
  logic [1:0]         ok_nxt;

  assign fire     = hold_v_r && out_ready;
  assign cur_last = !e_two_r || idx_r;
  assign free     = !hold_v_r || (fire && cur_last);
  assign load     = v_r[Last] && free;
  assign en       = !v_r[Last] || load;
  assign q_pop    = en && !q_empty;

  assign out_valid = hold_v_r;
  assign out_word  = idx_r ? e_w1_r : e_w0_r;
  assign out_last  = cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[sci_pkg::BackStages-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]    <= q_rdata.q;
      root_r[0]   <= '0;
      sq_job_r[0] <= q_rdata.job;
    end
  end

  for (genvar k = 0; k < sci_pkg::SW; k++) begin : g_sqrt
    logic [133:0] trial;
    logic         fits;
    always_comb begin
      trial = ({68'd0, root_r[k]} << (sci_pkg::SW - k))
            | ({{133{1'b0}}, 1'b1} << (2 * (sci_pkg::SW - 1 - k)));
      fits  = {2'b00, rem_r[k]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]    <= fits ? (rem_r[k] - trial[131:0]) : rem_r[k];
        root_r[k+1]   <= fits ? (root_r[k] | ({{65{1'b0}}, 1'b1} << (sci_pkg::SW - 1 - k)))
                              : root_r[k];
        sq_job_r[k+1] <= sq_job_r[k];
      end
    end
  end

  always_comb begin
    nh      = -{sq_job_r[sci_pkg::SW].h[66], sq_job_r[sci_pkg::SW].h};
    sq_ext  = {2'b00, root_r[sci_pkg::SW]};
    nm0_nxt = nh - sq_ext;
    nm1_nxt = nh + sq_ext;
    ok_nxt[0] = (n1_job_r.cls != sci_pkg::CLS_NONE) && !nm0_r[67]
             && (nm0_r[66:0] <= {1'b0, n1_job_r.a});
    ok_nxt[1] = (n1_job_r.cls == sci_pkg::CLS_TWO) && !nm1_r[67]
             && (nm1_r[66:0] <= {1'b0, n1_job_r.a});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm0_r        <= nm0_nxt;
      nm1_r        <= nm1_nxt;
      n1_job_r     <= sq_job_r[sci_pkg::SW];
      dv_n_r[0][0] <= {nm0_r[65:0], 16'd0};
      dv_n_r[0][1] <= {nm1_r[65:0], 16'd0};
      dv_t_r[0][0] <= '0;
      dv_t_r[0][1] <= '0;
      dv_ok_r[0]   <= ok_nxt;
      dv_job_r[0]  <= n1_job_r;
    end
  end

  for (genvar k = 0; k < sci_pkg::TW; k++) begin : g_div
    logic [81:0] dsr;
    assign dsr = {16'd0, dv_job_r[k].a} << (sci_pkg::TW - 1 - k);
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic fits;
      assign fits = dv_n_r[k][l] >= dsr;
      always_ff @(posedge clk) begin
        if (en) begin
          dv_n_r[k+1][l] <= fits ? (dv_n_r[k][l] - dsr) : dv_n_r[k][l];
          dv_t_r[k+1][l] <= fits ? (dv_t_r[k][l] | ({{16{1'b0}}, 1'b1} << (sci_pkg::TW - 1 - k)))
                                 : dv_t_r[k][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ok_r[k+1]  <= dv_ok_r[k];
        dv_job_r[k+1] <= dv_job_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        pr_r[l][0] <= dv_job_r[sci_pkg::TW].seg.dx * $signed({1'b0, dv_t_r[sci_pkg::TW][l]});
        pr_r[l][1] <= dv_job_r[sci_pkg::TW].seg.dy * $signed({1'b0, dv_t_r[sci_pkg::TW][l]});
        pr_r[l][2] <= dv_job_r[sci_pkg::TW].seg.dz * $signed({1'b0, dv_t_r[sci_pkg::TW][l]});
        l1_t_r[l]  <= dv_t_r[sci_pkg::TW][l];
      end
      l1_ok_r  <= dv_ok_r[sci_pkg::TW];
      l1_seg_r <= dv_job_r[sci_pkg::TW].seg;
      w0_r     <= w0_nxt;
      w1_r     <= w1_nxt;
      two_r    <= two_nxt;
    end
  end

  // floor shift of the product, then add start
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pt[l].hit = 1'b1;
      pt[l].px  = l1_seg_r.sx + pr_r[l][0][47:16];
      pt[l].py  = l1_seg_r.sy + pr_r[l][1][47:16];
      pt[l].pz  = l1_seg_r.sz + pr_r[l][2][47:16];
      pt[l].t   = l1_t_r[l];
    end
    w0_nxt  = '0;
    w1_nxt  = '0;
    two_nxt = 1'b0;
    unique case (l1_ok_r)
      2'b11: begin
        w0_nxt  = pt[0];
        w1_nxt  = pt[1];
        two_nxt = 1'b1;
      end
      2'b01:   w0_nxt = pt[0];
      2'b10:   w0_nxt = pt[1];
      default: w0_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      idx_r    <= 1'b0;
    end else if (load) begin
      hold_v_r <= 1'b1;
      idx_r    <= 1'b0;
    end else if (fire) begin
      hold_v_r <= !cur_last;
      idx_r    <= !cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e_w0_r  <= w0_r;
      e_w1_r  <= w1_r;
      e_two_r <= two_r;
    end
  end

  `SCI_CHECK(a_b_idx, !(hold_v_r && idx_r && !e_two_r), "second word without a pair")
  `SCI_CHECK(a_b_miss_last, !out_valid || out_word.hit || out_last, "miss word not last")
  `SCI_CHECK_NEXT(a_b_second, fire && !cur_last, hold_v_r && idx_r, "second word dropped")

endmodule
